FILE: hdl/i2c_eeprom_transfer_sequencer_core_assert.svh
// ----------------------------------------------------------------------------
// I2C EEPROM transfer sequencer - assertion macros
// Implication checks on clk/rst_n, reported through $error.
// ----------------------------------------------------------------------------
`ifndef I2C_EEPROM_TRANSFER_SEQUENCER_CORE_ASSERT_SVH
`define I2C_EEPROM_TRANSFER_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication
`define I2CEES_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2cees assertion failed");

// next-cycle implication
`define I2CEES_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2cees assertion failed");

`endif

FILE: hdl/i2cees_pkg.sv
// ----------------------------------------------------------------------------
// i2cees_pkg
// Shared types, codes and helpers of the I2C EEPROM transfer sequencer.
// ----------------------------------------------------------------------------
package i2cees_pkg;

  localparam int unsigned PAGE_BYTES = 8;
  localparam int unsigned PAGE_BITS  = $clog2(PAGE_BYTES);
  localparam int unsigned MAX_RES    = 3;
  localparam int unsigned Q_DEPTH    = 8;
  localparam int unsigned Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W    = Q_PTR_W + 1;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_DATA  = 2'd2,
    ACT_REPLY = 2'd3
  } act_e;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_START  = 3'd1,
    OP_STOP   = 3'd2,
    OP_SEND   = 3'd3,
    OP_RDACK  = 3'd4,
    OP_RDNACK = 3'd5
  } op_e;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_R_DEVW = 9'b000000010,
    ST_R_ADDR = 9'b000000100,
    ST_R_DEVR = 9'b000001000,
    ST_R_DATA = 9'b000010000,
    ST_W_POLL = 9'b000100000,
    ST_W_ADDR = 9'b001000000,
    ST_W_NEED = 9'b010000000,
    ST_W_DATA = 9'b100000000
  } st_e;

  typedef enum logic {
    REG_DEVICE_BASE = 1'b0,
    REG_POLL_LIMIT  = 1'b1
  } reg_e;

  localparam logic [7:0] DEVICE_BASE_RST = 8'd160;
  localparam logic [7:0] POLL_LIMIT_RST  = 8'd100;

  typedef struct packed {
    op_e        bus_op;
    logic [7:0] bus_byte;
    logic       data_valid;
    logic [7:0] read_data;
    logic       need_data;
    logic       done_res;
    logic       success;
    logic       last;
  } res_t;

  function automatic res_t mk_res(op_e op, logic [7:0] b, logic dv, logic [7:0] rd,
                                  logic need, logic done, logic ok);
    res_t r;
    r.bus_op     = op;
    r.bus_byte   = b;
    r.data_valid = dv;
    r.read_data  = rd;
    r.need_data  = need;
    r.done_res   = done;
    r.success    = ok;
    r.last       = 1'b0;
    return r;
  endfunction

  // device byte: base | page bits << 1 | direction
  function automatic logic [7:0] dev_byte(logic [7:0] base, logic [10:0] addr, logic rw);
    return base | {4'b0000, addr[10:8], 1'b0} | {7'b0000000, rw};
  endfunction

endpackage

FILE: hdl/i2cees_regs.sv
// ----------------------------------------------------------------------------
// i2cees_regs
// APB configuration registers: device base byte and ack-poll limit.
// ----------------------------------------------------------------------------
module i2cees_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic [7:0]  device_base_o,
  output logic [7:0]  poll_limit_o
);

  logic       wr_en;
  logic [7:0] device_base_q;
  logic [7:0] poll_limit_q;

  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_base_q <= i2cees_pkg::DEVICE_BASE_RST;
      poll_limit_q  <= i2cees_pkg::POLL_LIMIT_RST;
    end else if (wr_en) begin
      case (i2cees_pkg::reg_e'(paddr[2]))
        i2cees_pkg::REG_DEVICE_BASE: device_base_q <= pwdata[7:0];
        i2cees_pkg::REG_POLL_LIMIT:  poll_limit_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (i2cees_pkg::reg_e'(paddr[2]))
      i2cees_pkg::REG_DEVICE_BASE: prdata = {24'd0, device_base_q};
      i2cees_pkg::REG_POLL_LIMIT:  prdata = {24'd0, poll_limit_q};
      default:                     prdata = '0;
    endcase
  end

  assign device_base_o = device_base_q;
  assign poll_limit_o  = poll_limit_q;

endmodule

FILE: hdl/i2cees_seq.sv
// ----------------------------------------------------------------------------
// i2cees_seq
// Transfer state machine: one accepted word updates state and yields up to
// three bus results.
// ----------------------------------------------------------------------------
module i2cees_seq #(
  parameter int unsigned ADDR_BITS = 11
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [1:0]              action_i,
  input  logic [10:0]             start_address_i,
  input  logic [11:0]             length_i,
  input  logic [7:0]              write_data_i,
  input  logic                    ack_ok_i,
  input  logic [7:0]              read_byte_i,
  input  logic [7:0]              device_base_i,
  input  logic [7:0]              poll_limit_i,
  output i2cees_pkg::res_t        res_o [i2cees_pkg::MAX_RES],
  output logic [1:0]              res_cnt_o
);

  i2cees_pkg::st_e        st_q, st_d;
  logic [ADDR_BITS-1:0]   addr_q, addr_d, addr_inc, addr_new;
  logic [11:0]            left_q, left_d, left_dec;
  logic [7:0]             poll_q, poll_d, lim;
  i2cees_pkg::res_t       res [i2cees_pkg::MAX_RES];
  logic [1:0]             cnt, last_idx;

  assign addr_inc = addr_q + 1'b1;
  assign addr_new = start_address_i[ADDR_BITS-1:0];
  assign left_dec = left_q - 12'd1;
  assign lim      = (poll_limit_i == 8'd0) ? 8'd1 : poll_limit_i;
  assign last_idx = cnt - 2'd1;

  always_comb begin
    st_d   = st_q;
    addr_d = addr_q;
    left_d = left_q;
    poll_d = poll_q;
    cnt    = 2'd0;
    for (int k = 0; k < i2cees_pkg::MAX_RES; k++) begin
      res[k] = '0;
    end
    if (accept_i) begin
      case (i2cees_pkg::act_e'(action_i))
        i2cees_pkg::ACT_READ, i2cees_pkg::ACT_WRITE: begin
          if (st_q == i2cees_pkg::ST_IDLE) begin
            addr_d = addr_new;
            left_d = length_i;
            poll_d = 8'd0;
            if (length_i == 12'd0) begin
              res[0] = i2cees_pkg::mk_res(i2cees_pkg::OP_STOP, 8'd0, 1'b0, 8'd0,
                                          1'b0, 1'b1, 1'b1);
              cnt    = 2'd1;
            end else if (i2cees_pkg::act_e'(action_i) == i2cees_pkg::ACT_READ) begin
              st_d   = i2cees_pkg::ST_R_DEVW;
              res[0] = i2cees_pkg::mk_res(i2cees_pkg::OP_START, 8'd0, 1'b0, 8'd0,
                                          1'b0, 1'b0, 1'b0);
              res[1] = i2cees_pkg::mk_res(i2cees_pkg::OP_SEND,
                         i2cees_pkg::dev_byte(device_base_i, 11'(addr_new), 1'b0),
                         1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
              cnt    = 2'd2;
            end else begin
              st_d   = i2cees_pkg::ST_W_POLL;
              poll_d = 8'd1;
              res[0] = i2cees_pkg::mk_res(i2cees_pkg::OP_STOP, 8'd0, 1'b0, 8'd0,
                                          1'b0, 1'b0, 1'b0);
              res[1] = i2cees_pkg::mk_res(i2cees_pkg::OP_START, 8'd0, 1'b0, 8'd0,
                                          1'b0, 1'b0, 1'b0);
              res[2] = i2cees_pkg::mk_res(i2cees_pkg::OP_SEND,
                         i2cees_pkg::dev_byte(device_base_i, 11'(addr_new), 1'b0),
                         1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
              cnt    = 2'd3;
            end
          end
        end
        i2cees_pkg::ACT_DATA: begin
          if (st_q == i2cees_pkg::ST_W_NEED) begin
            st_d   = i2cees_pkg::ST_W_DATA;
            res[0] = i2cees_pkg::mk_res(i2cees_pkg::OP_SEND, write_data_i, 1'b0, 8'd0,
                                        1'b0, 1'b0, 1'b0);
            cnt    = 2'd1;
          end
        end
        default: begin
          case (st_q)
            i2cees_pkg::ST_R_DEVW, i2cees_pkg::ST_R_ADDR, i2cees_pkg::ST_R_DEVR,
            i2cees_pkg::ST_W_ADDR, i2cees_pkg::ST_W_DATA: begin
              if (!ack_ok_i) begin
                st_d   = i2cees_pkg::ST_IDLE;
                res[0] = i2cees_pkg::mk_res(i2cees_pkg::OP_STOP, 8'd0, 1'b0, 8'd0,
                                            1'b0, 1'b1, 1'b0);
                cnt    = 2'd1;
              end else if (st_q == i2cees_pkg::ST_R_DEVW) begin
                st_d   = i2cees_pkg::ST_R_ADDR;
                res[0] = i2cees_pkg::mk_res(i2cees_pkg::OP_SEND, addr_q[7:0], 1'b0, 8'd0,
                                            1'b0, 1'b0, 1'b0);
                cnt    = 2'd1;
              end else if (st_q == i2cees_pkg::ST_R_ADDR) begin
                st_d   = i2cees_pkg::ST_R_DEVR;
                res[0] = i2cees_pkg::mk_res(i2cees_pkg::OP_START, 8'd0, 1'b0, 8'd0,
                                            1'b0, 1'b0, 1'b0);
                res[1] = i2cees_pkg::mk_res(i2cees_pkg::OP_SEND,
                           i2cees_pkg::dev_byte(device_base_i, 11'(addr_q), 1'b1),
                           1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
                cnt    = 2'd2;
              end else if (st_q == i2cees_pkg::ST_R_DEVR) begin
                st_d   = i2cees_pkg::ST_R_DATA;
                res[0] = i2cees_pkg::mk_res((left_q > 12'd1) ? i2cees_pkg::OP_RDACK
                                                             : i2cees_pkg::OP_RDNACK,
                                            8'd0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
                cnt    = 2'd1;
              end else if (st_q == i2cees_pkg::ST_W_ADDR) begin
                st_d   = i2cees_pkg::ST_W_NEED;
                res[0] = i2cees_pkg::mk_res(i2cees_pkg::OP_NONE, 8'd0, 1'b0, 8'd0,
                                            1'b1, 1'b0, 1'b0);
                cnt    = 2'd1;
              end else begin
                addr_d = addr_inc;
                left_d = left_dec;
                cnt    = 2'd1;
                if (left_dec == 12'd0) begin
                  st_d   = i2cees_pkg::ST_IDLE;
                  res[0] = i2cees_pkg::mk_res(i2cees_pkg::OP_STOP, 8'd0, 1'b0, 8'd0,
                                              1'b0, 1'b1, 1'b1);
                end else if (addr_inc[i2cees_pkg::PAGE_BITS-1:0] == '0) begin
                  st_d   = i2cees_pkg::ST_W_POLL;
                  poll_d = 8'd1;
                  res[0] = i2cees_pkg::mk_res(i2cees_pkg::OP_STOP, 8'd0, 1'b0, 8'd0,
                                              1'b0, 1'b0, 1'b0);
                  res[1] = i2cees_pkg::mk_res(i2cees_pkg::OP_START, 8'd0, 1'b0, 8'd0,
                                              1'b0, 1'b0, 1'b0);
                  res[2] = i2cees_pkg::mk_res(i2cees_pkg::OP_SEND,
                             i2cees_pkg::dev_byte(device_base_i, 11'(addr_inc), 1'b0),
                             1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
                  cnt    = 2'd3;
                end else begin
                  st_d   = i2cees_pkg::ST_W_NEED;
                  res[0] = i2cees_pkg::mk_res(i2cees_pkg::OP_NONE, 8'd0, 1'b0, 8'd0,
                                              1'b1, 1'b0, 1'b0);
                end
              end
            end
            i2cees_pkg::ST_R_DATA: begin
              addr_d = addr_inc;
              left_d = left_dec;
              cnt    = 2'd1;
              if (left_dec == 12'd0) begin
                st_d   = i2cees_pkg::ST_IDLE;
                res[0] = i2cees_pkg::mk_res(i2cees_pkg::OP_STOP, 8'd0, 1'b1, read_byte_i,
                                            1'b0, 1'b1, 1'b1);
              end else begin
                res[0] = i2cees_pkg::mk_res((left_dec > 12'd1) ? i2cees_pkg::OP_RDACK
                                                               : i2cees_pkg::OP_RDNACK,
                                            8'd0, 1'b1, read_byte_i, 1'b0, 1'b0, 1'b0);
              end
            end
            i2cees_pkg::ST_W_POLL: begin
              if (ack_ok_i) begin
                st_d   = i2cees_pkg::ST_W_ADDR;
                res[0] = i2cees_pkg::mk_res(i2cees_pkg::OP_SEND, addr_q[7:0], 1'b0, 8'd0,
                                            1'b0, 1'b0, 1'b0);
                cnt    = 2'd1;
              end else if (poll_q >= lim) begin
                st_d   = i2cees_pkg::ST_IDLE;
                res[0] = i2cees_pkg::mk_res(i2cees_pkg::OP_STOP, 8'd0, 1'b0, 8'd0,
                                            1'b0, 1'b1, 1'b0);
                cnt    = 2'd1;
              end else begin
                poll_d = poll_q + 8'd1;
                res[0] = i2cees_pkg::mk_res(i2cees_pkg::OP_START, 8'd0, 1'b0, 8'd0,
                                            1'b0, 1'b0, 1'b0);
                res[1] = i2cees_pkg::mk_res(i2cees_pkg::OP_SEND,
                           i2cees_pkg::dev_byte(device_base_i, 11'(addr_q), 1'b0),
                           1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
                cnt    = 2'd2;
              end
            end
            default: ;
          endcase
        end
      endcase
    end
    if (cnt != 2'd0) begin
      res[last_idx].last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= i2cees_pkg::ST_IDLE;
      addr_q <= '0;
      left_q <= '0;
      poll_q <= '0;
    end else begin
      st_q   <= st_d;
      addr_q <= addr_d;
      left_q <= left_d;
      poll_q <= poll_d;
    end
  end

  assign res_o     = res;
  assign res_cnt_o = cnt;

endmodule

FILE: hdl/i2cees_outq.sv
// ----------------------------------------------------------------------------
// i2cees_outq
// Result queue: takes up to three words per cycle, hands out one per cycle.
// ----------------------------------------------------------------------------
module i2cees_outq (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  i2cees_pkg::res_t        push_res_i [i2cees_pkg::MAX_RES],
  input  logic [1:0]              push_cnt_i,
  output logic                    room_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output i2cees_pkg::res_t        out_res_o
);

  localparam int unsigned PW = i2cees_pkg::Q_PTR_W;
  localparam int unsigned CW = i2cees_pkg::Q_CNT_W;

  i2cees_pkg::res_t mem_q [i2cees_pkg::Q_DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_res_o   = mem_q[rd_ptr_q];
  assign room_o      = (cnt_q <= CW'(i2cees_pkg::Q_DEPTH - i2cees_pkg::MAX_RES));

  assign wr_ptr_d = wr_ptr_q + PW'(push_cnt_i);
  assign rd_ptr_d = rd_ptr_q + PW'(pop);
  assign cnt_d    = cnt_q + CW'(push_cnt_i) - CW'(pop);

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < i2cees_pkg::MAX_RES; k++) begin
      if (k < int'(push_cnt_i)) begin
        mem_q[wr_ptr_q + PW'(k)] <= push_res_i[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

FILE: hdl/i2c_eeprom_transfer_sequencer_core.sv
// Into an empty queue, an item's first result word is offered the cycle after intake.
// Throughput: one item per cycle while the result queue has room for three words;
// results leave one word per cycle with out_ready_i high, pacing multi-word items.
// Reset: asynchronous, active low; sequencer idle, queue empty, registers at defaults.
// ----------------------------------------------------------------------------
// i2c_eeprom_transfer_sequencer_core
// I2C master-side random-read / page-write sequencer for 24xx serial EEPROMs.
// ----------------------------------------------------------------------------
module i2c_eeprom_transfer_sequencer_core #(
  parameter int unsigned ADDR_BITS = 11
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [10:0] start_address_i,
  input  logic [11:0] length_i,
  input  logic [7:0]  write_data_i,
  input  logic        ack_ok_i,
  input  logic [7:0]  read_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  bus_op_o,
  output logic [7:0]  bus_byte_o,
  output logic        data_valid_o,
  output logic [7:0]  read_data_o,
  output logic        need_data_o,
  output logic        done_res_o,
  output logic        success_o,
  output logic        last_o
);

  logic             accept;
  logic [7:0]       device_base;
  logic [7:0]       poll_limit;
  i2cees_pkg::res_t res [i2cees_pkg::MAX_RES];
  logic [1:0]       res_cnt;
  logic             room;
  i2cees_pkg::res_t out_res;

  assign pready     = 1'b1;
  assign in_ready_o = room;
  assign accept     = in_valid_i && room;

  i2cees_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .device_base_o (device_base),
    .poll_limit_o  (poll_limit)
  );

  i2cees_seq #(
    .ADDR_BITS (ADDR_BITS)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .action_i        (action_i),
    .start_address_i (start_address_i),
    .length_i        (length_i),
    .write_data_i    (write_data_i),
    .ack_ok_i        (ack_ok_i),
    .read_byte_i     (read_byte_i),
    .device_base_i   (device_base),
    .poll_limit_i    (poll_limit),
    .res_o           (res),
    .res_cnt_o       (res_cnt)
  );

  i2cees_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_res_i  (res),
    .push_cnt_i  (res_cnt),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res)
  );

  assign bus_op_o     = out_res.bus_op;
  assign bus_byte_o   = out_res.bus_byte;
  assign data_valid_o = out_res.data_valid;
  assign read_data_o  = out_res.read_data;
  assign need_data_o  = out_res.need_data;
  assign done_res_o   = out_res.done_res;
  assign success_o    = out_res.success;
  assign last_o       = out_res.last;

endmodule

FILE: hdl/i2cees_checker.sv
// ----------------------------------------------------------------------------
// i2cees_checker
// Port-level checks on result words of the transfer sequencer.
// ----------------------------------------------------------------------------
`include "i2c_eeprom_transfer_sequencer_core_assert.svh"

module i2cees_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  bus_op_o,
  input logic [7:0]  bus_byte_o,
  input logic        data_valid_o,
  input logic        need_data_o,
  input logic        done_res_o,
  input logic        success_o,
  input logic        last_o
);

  `I2CEES_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(bus_op_o) && $stable(bus_byte_o) && $stable(last_o))

  `I2CEES_ASSERT_IMP(a_done_stop, clk_i, rst_ni, out_valid_o && done_res_o, bus_op_o == i2cees_pkg::OP_STOP && last_o)

  `I2CEES_ASSERT_IMP(a_ok_done, clk_i, rst_ni, out_valid_o && success_o, done_res_o)

  `I2CEES_ASSERT_IMP(a_dv_op, clk_i, rst_ni, out_valid_o && data_valid_o, bus_op_o == i2cees_pkg::OP_STOP || bus_op_o == i2cees_pkg::OP_RDACK || bus_op_o == i2cees_pkg::OP_RDNACK)

  `I2CEES_ASSERT_IMP(a_need_none, clk_i, rst_ni, out_valid_o && need_data_o, bus_op_o == i2cees_pkg::OP_NONE && last_o && !done_res_o)

endmodule

bind i2c_eeprom_transfer_sequencer_core i2cees_checker u_i2cees_checker (.*);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - I2C EEPROM transfer sequencer testbench
// A model of the sequencer inside the scoreboard predicts each result word as
// input words are taken. The stimulus starts with a directed list and then
// runs random read and page write transfers under several register settings.
// Both handshakes idle at random, and the output words are compared in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES = 8;

  class eeprom_bus_board;
    logic [7:0]       base  = i2cees_pkg::DEVICE_BASE_RST;
    logic [7:0]       limit = i2cees_pkg::POLL_LIMIT_RST;
    i2cees_pkg::st_e  state = i2cees_pkg::ST_IDLE;
    logic [10:0]      cur_addr = '0;
    logic [11:0]      left = '0;
    logic [7:0]       polls = '0;
    i2cees_pkg::res_t expected_words[$];
    i2cees_pkg::res_t batch[$];
    int               errors = 0;
    int               checked = 0;

    function void load_reg(i2cees_pkg::reg_e idx, logic [7:0] value);
      if (idx == i2cees_pkg::REG_DEVICE_BASE) base = value;
      else limit = value;
    endfunction

    function void emit(i2cees_pkg::op_e op, logic [7:0] b, logic dv, logic [7:0] rd,
                       logic need, logic done, logic ok);
      i2cees_pkg::res_t w;
      w.bus_op     = op;
      w.bus_byte   = b;
      w.data_valid = dv;
      w.read_data  = rd;
      w.need_data  = need;
      w.done_res   = done;
      w.success    = ok;
      w.last       = 1'b0;
      batch.push_back(w);
    endfunction

    function logic [7:0] dev_code(logic rw);
      return base | {4'b0000, cur_addr[10:8], rw};
    endfunction

    function void close(logic ok);
      emit(i2cees_pkg::OP_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, ok);
      state = i2cees_pkg::ST_IDLE;
    endfunction

    function void readdress();
      emit(i2cees_pkg::OP_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
      emit(i2cees_pkg::OP_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
      emit(i2cees_pkg::OP_SEND, dev_code(1'b0), 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
      polls = 8'd1;
      state = i2cees_pkg::ST_W_POLL;
    endfunction

    function void take_reply(logic ack, logic [7:0] rb);
      logic [7:0] lim;
      case (state)
        i2cees_pkg::ST_R_DEVW: begin
          if (!ack) close(1'b0);
          else begin
            emit(i2cees_pkg::OP_SEND, cur_addr[7:0], 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
            state = i2cees_pkg::ST_R_ADDR;
          end
        end
        i2cees_pkg::ST_R_ADDR: begin
          if (!ack) close(1'b0);
          else begin
            emit(i2cees_pkg::OP_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
            emit(i2cees_pkg::OP_SEND, dev_code(1'b1), 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
            state = i2cees_pkg::ST_R_DEVR;
          end
        end
        i2cees_pkg::ST_R_DEVR: begin
          if (!ack) close(1'b0);
          else begin
            emit((left > 1) ? i2cees_pkg::OP_RDACK : i2cees_pkg::OP_RDNACK,
                 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
            state = i2cees_pkg::ST_R_DATA;
          end
        end
        i2cees_pkg::ST_R_DATA: begin
          left = left - 12'd1;
          cur_addr = cur_addr + 11'd1;
          if (left == 0) begin
            emit(i2cees_pkg::OP_STOP, 8'h00, 1'b1, rb, 1'b0, 1'b1, 1'b1);
            state = i2cees_pkg::ST_IDLE;
          end else begin
            emit((left > 1) ? i2cees_pkg::OP_RDACK : i2cees_pkg::OP_RDNACK,
                 8'h00, 1'b1, rb, 1'b0, 1'b0, 1'b0);
          end
        end
        i2cees_pkg::ST_W_POLL: begin
          if (ack) begin
            emit(i2cees_pkg::OP_SEND, cur_addr[7:0], 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
            state = i2cees_pkg::ST_W_ADDR;
          end else begin
            lim = (limit == 0) ? 8'd1 : limit;
            if (polls >= lim) close(1'b0);
            else begin
              polls = polls + 8'd1;
              emit(i2cees_pkg::OP_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
              emit(i2cees_pkg::OP_SEND, dev_code(1'b0), 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
            end
          end
        end
        i2cees_pkg::ST_W_ADDR: begin
          if (!ack) close(1'b0);
          else begin
            emit(i2cees_pkg::OP_NONE, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0);
            state = i2cees_pkg::ST_W_NEED;
          end
        end
        i2cees_pkg::ST_W_DATA: begin
          if (!ack) close(1'b0);
          else begin
            cur_addr = cur_addr + 11'd1;
            left = left - 12'd1;
            if (left == 0) close(1'b1);
            else if (cur_addr % i2cees_pkg::PAGE_BYTES == 0) readdress();
            else begin
              emit(i2cees_pkg::OP_NONE, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0);
              state = i2cees_pkg::ST_W_NEED;
            end
          end
        end
        default: ;
      endcase
    endfunction

    // returns the number of result words the input word causes
    function int take_item(i2cees_pkg::act_e act, logic [10:0] addr, logic [11:0] len,
                           logic [7:0] wd, logic ack, logic [7:0] rb);
      batch.delete();
      case (act)
        i2cees_pkg::ACT_READ, i2cees_pkg::ACT_WRITE: begin
          if (state == i2cees_pkg::ST_IDLE) begin
            cur_addr = addr;
            left = len;
            polls = 8'd0;
            if (len == 0) close(1'b1);
            else if (act == i2cees_pkg::ACT_READ) begin
              emit(i2cees_pkg::OP_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
              emit(i2cees_pkg::OP_SEND, dev_code(1'b0), 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
              state = i2cees_pkg::ST_R_DEVW;
            end else begin
              readdress();
            end
          end
        end
        i2cees_pkg::ACT_DATA: begin
          if (state == i2cees_pkg::ST_W_NEED) begin
            emit(i2cees_pkg::OP_SEND, wd, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
            state = i2cees_pkg::ST_W_DATA;
          end
        end
        default: take_reply(ack, rb);
      endcase
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) expected_words.push_back(batch[i]);
      return batch.size();
    endfunction

    function void check_word(i2cees_pkg::res_t got);
      i2cees_pkg::res_t exp;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word op=%0d byte=%h dv=%b rd=%h need=%b done=%b ok=%b last=%b",
                 $time, got.bus_op, got.bus_byte, got.data_valid, got.read_data,
                 got.need_data, got.done_res, got.success, got.last);
        errors++;
        return;
      end
      exp = expected_words.pop_front();
      checked++;
      if (got !== exp) begin
        $display("%0t: mismatch exp op=%0d byte=%h dv=%b rd=%h need=%b done=%b ok=%b last=%b",
                 $time, exp.bus_op, exp.bus_byte, exp.data_valid, exp.read_data,
                 exp.need_data, exp.done_res, exp.success, exp.last);
        $display("%0t:          got op=%0d byte=%h dv=%b rd=%h need=%b done=%b ok=%b last=%b",
                 $time, got.bus_op, got.bus_byte, got.data_valid, got.read_data,
                 got.need_data, got.done_res, got.success, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid, in_ready_o;
  logic [1:0]  action;
  logic [10:0] start_address;
  logic [11:0] length;
  logic [7:0]  write_data;
  logic        ack_ok;
  logic [7:0]  read_byte;
  logic        out_valid_o, out_ready;
  logic [2:0]  bus_op_o;
  logic [7:0]  bus_byte_o;
  logic        data_valid_o;
  logic [7:0]  read_data_o;
  logic        need_data_o, done_res_o, success_o, last_o;

  eeprom_bus_board  board;
  i2cees_pkg::res_t seen;
  bit               calm = 1'b0;
  int               taken_items = 0;
  int               busy_items = 0;
  int               settings = 0;
  int unsigned      stall_cycles = 0;

  i2c_eeprom_transfer_sequencer_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .action_i       (action),
    .start_address_i(start_address),
    .length_i       (length),
    .write_data_i   (write_data),
    .ack_ok_i       (ack_ok),
    .read_byte_i    (read_byte),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .bus_op_o       (bus_op_o),
    .bus_byte_o     (bus_byte_o),
    .data_valid_o   (data_valid_o),
    .read_data_o    (read_data_o),
    .need_data_o    (need_data_o),
    .done_res_o     (done_res_o),
    .success_o      (success_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: random stalls until the calm tail
  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      seen.bus_op     = i2cees_pkg::op_e'(bus_op_o);
      seen.bus_byte   = bus_byte_o;
      seen.data_valid = data_valid_o;
      seen.read_data  = read_data_o;
      seen.need_data  = need_data_o;
      seen.done_res   = done_res_o;
      seen.success    = success_o;
      seen.last       = last_o;
      board.check_word(seen);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) stall_cycles <= 0;
    else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("[i2c_eeprom_transfer_sequencer_core] ERROR");
      $finish;
    end else stall_cycles <= stall_cycles + 1;
  end

  task automatic push_item(i2cees_pkg::act_e act, logic [10:0] addr, logic [11:0] len,
                           logic [7:0] wd, logic ack, logic [7:0] rb);
    int made;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid      = 1'b1;
    action        = act;
    start_address = addr;
    length        = len;
    write_data    = wd;
    ack_ok        = ack;
    read_byte     = rb;
    do @(posedge clk_i); while (!in_ready_o);
    made = board.take_item(act, addr, len, wd, ack, rb);
    taken_items++;
    if (made > 0) busy_items++;
  endtask

  task automatic cmd(i2cees_pkg::act_e act, logic [10:0] addr, logic [11:0] len);
    push_item(act, addr, len, 8'($urandom), 1'($urandom), 8'($urandom));
  endtask

  task automatic reply(logic ack, logic [7:0] rb);
    push_item(i2cees_pkg::ACT_REPLY, 11'($urandom), 12'($urandom), 8'($urandom), ack, rb);
  endtask

  task automatic give(logic [7:0] wd);
    push_item(i2cees_pkg::ACT_DATA, 11'($urandom), 12'($urandom), wd, 1'($urandom),
              8'($urandom));
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (board.expected_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_reg(i2cees_pkg::reg_e idx, logic [7:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {24'h000000, value};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    board.load_reg(idx, value);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic reconfigure(logic [7:0] base, logic [7:0] limit);
    settle();
    set_reg(i2cees_pkg::REG_DEVICE_BASE, base);
    set_reg(i2cees_pkg::REG_POLL_LIMIT, limit);
    settings++;
  endtask

  // one random transfer, mostly well-formed, with ignored words mixed in
  task automatic run_transfer();
    i2cees_pkg::act_e act, noise_act;
    logic [11:0]      len;
    bit               long_len, stubborn;
    logic             ack;
    int               pick;
    act = $urandom_range(0, 1) ? i2cees_pkg::ACT_WRITE : i2cees_pkg::ACT_READ;
    pick = $urandom_range(0, 9);
    if (pick == 0) len = 12'd0;
    else if (pick == 1) len = 12'($urandom_range(25, 4095));
    else len = 12'($urandom_range(1, 12));
    long_len = (len > 24);
    stubborn = (board.limit <= 16) && ($urandom_range(0, 5) == 0);
    cmd(act, 11'($urandom_range(0, 2047)), len);
    while (board.state != i2cees_pkg::ST_IDLE) begin
      if ($urandom_range(0, 7) == 0) begin
        if (board.state == i2cees_pkg::ST_W_NEED)
          noise_act = $urandom_range(0, 1) ? i2cees_pkg::ACT_REPLY
                                           : i2cees_pkg::act_e'($urandom_range(0, 1));
        else
          noise_act = $urandom_range(0, 1) ? i2cees_pkg::ACT_DATA
                                           : i2cees_pkg::act_e'($urandom_range(0, 1));
        push_item(noise_act, 11'($urandom), 12'($urandom), 8'($urandom),
                  1'($urandom), 8'($urandom));
      end
      if (board.state == i2cees_pkg::ST_W_NEED) begin
        give(8'($urandom));
      end else begin
        case (board.state)
          i2cees_pkg::ST_W_POLL:
            ack = stubborn ? 1'b0 : ($urandom_range(0, 2) != 0);
          i2cees_pkg::ST_R_DATA:
            ack = 1'($urandom);
          i2cees_pkg::ST_R_DEVR:
            ack = long_len ? 1'b0 : ($urandom_range(0, 15) != 0);
          i2cees_pkg::ST_W_DATA:
            ack = long_len ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 15) != 0);
          default:
            ack = ($urandom_range(0, 15) != 0);
        endcase
        reply(ack, 8'($urandom));
      end
    end
  endtask

  initial begin
    logic [7:0] bases[5];
    logic [7:0] limits[5];
    int         target;
    board = new();
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    action        = i2cees_pkg::ACT_READ;
    start_address = '0;
    length        = '0;
    write_data    = '0;
    ack_ok        = 1'b0;
    read_byte     = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part at reset settings, then with a poll limit of one
    cmd(i2cees_pkg::ACT_READ, 11'h7ff, 12'd0);
    cmd(i2cees_pkg::ACT_WRITE, 11'h000, 12'd0);
    reply(1'b1, 8'h00);
    give(8'hff);
    cmd(i2cees_pkg::ACT_READ, 11'h7ff, 12'd2);
    cmd(i2cees_pkg::ACT_WRITE, 11'h000, 12'd5);
    give(8'h5a);
    reply(1'b1, 8'h00);
    reply(1'b1, 8'h00);
    reply(1'b1, 8'h00);
    reply(1'b0, 8'hff);
    reply(1'b1, 8'h00);
    cmd(i2cees_pkg::ACT_READ, 11'h100, 12'hfff);
    reply(1'b0, 8'h00);
    cmd(i2cees_pkg::ACT_WRITE, 11'h7fe, 12'd3);
    reply(1'b0, 8'h00);
    reply(1'b1, 8'h00);
    reply(1'b1, 8'h00);
    reply(1'b1, 8'h00);
    cmd(i2cees_pkg::ACT_READ, 11'h000, 12'd1);
    give(8'hff);
    reply(1'b1, 8'h00);
    give(8'h00);
    reply(1'b1, 8'h00);
    reply(1'b1, 8'h00);
    reply(1'b1, 8'h00);
    give(8'ha5);
    reply(1'b1, 8'h00);
    reconfigure(i2cees_pkg::DEVICE_BASE_RST, 8'd1);
    cmd(i2cees_pkg::ACT_WRITE, 11'h123, 12'd4);
    reply(1'b0, 8'h00);

    bases  = '{8'h00, 8'hff, 8'($urandom), 8'ha6, 8'($urandom)};
    limits = '{8'd1, 8'd255, 8'd0, 8'($urandom_range(2, 8)), 8'd3};
    for (int p = 0; p < 5; p++) begin
      reconfigure(bases[p], limits[p]);
      if (p == 4) calm = 1'b1;
      target = busy_items + 12;
      while (busy_items < target) run_transfer();
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d input words (%0d causing bus activity), %0d result words checked",
             taken_items, busy_items, board.checked);
    $display("reads, page writes, polling and nack exits over %0d register settings",
             settings);
    if (board.errors == 0 && board.expected_words.size() == 0) begin
      $display("[i2c_eeprom_transfer_sequencer_core] OK");
    end else begin
      $display("%0d errors, %0d words never seen", board.errors,
               board.expected_words.size());
      $display("[i2c_eeprom_transfer_sequencer_core] ERROR");
    end
    $finish;
  end

endmodule

FILE: i2c_eeprom_transfer_sequencer_core.f
+incdir+hdl
hdl/i2cees_pkg.sv
hdl/i2cees_regs.sv
hdl/i2cees_seq.sv
hdl/i2cees_outq.sv
hdl/i2c_eeprom_transfer_sequencer_core.sv
hdl/i2cees_checker.sv
verif/tb_top.sv
